### hw/rtl/cnfp_pkg.sv
// ----------------------------------------------------------------------------
// cnfp_pkg
// Types, limits and codes shared by the crossing number feature point blocks.
// ----------------------------------------------------------------------------
package cnfp_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_POINTS  = 48;

  localparam int PIX_W       = 8;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 8;
  localparam int CNT_W       = 6;
  localparam int FW_W        = 8;
  localparam int FH_W        = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int SUM_W       = 11;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 8'd90;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 9'd160;

  // crossing sum: line end, or branch and beyond
  localparam logic [SUM_W-1:0] SUM_END    = 11'd2;
  localparam logic [SUM_W-1:0] SUM_BRANCH = 11'd6;

  // record kinds between front and back
  localparam logic [1:0] REC_CLEAR   = 2'd0;
  localparam logic [1:0] REC_POINT   = 2'd1;
  localparam logic [1:0] REC_SUMMARY = 2'd2;

  // clockwise ring over the 3x3 window, row-major indexes
  localparam logic [7:0][3:0] RING = {4'd3, 4'd6, 4'd7, 4'd8, 4'd5, 4'd2, 4'd1, 4'd0};

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_t;

  typedef struct packed {
    logic [ROW_W-1:0] point_row;
    logic [COL_W-1:0] point_col;
    logic             is_summary;
    logic [CNT_W-1:0] point_count;
    logic             overflow;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             feat_after;
    logic             summ_after;
  } rec_t;

  typedef logic [8:0][PIX_W-1:0] win_t;

  function automatic logic is_feature(input win_t w);
    logic [7:0][SUM_W-1:0] d;
    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    for (int k = 0; k < 8; k++) begin
      a    = w[RING[k]];
      b    = w[RING[(k + 1) & 7]];
      d[k] = SUM_W'((a > b) ? (a - b) : (b - a));
    end
    // adder tree
    sum = ((d[0] + d[1]) + (d[2] + d[3])) + ((d[4] + d[5]) + (d[6] + d[7]));
    return (w[4] != '0) && ((sum == SUM_END) || (sum >= SUM_BRANCH));
  endfunction

endpackage

### hw/rtl/cnfp_front.sv
// ----------------------------------------------------------------------------
// cnfp_front
// Raster position, line buffers, 3x3 window and crossing number checks.
// Emits clear and point records; walks the bottom row at the end of a frame, then emits a summary record.
// ----------------------------------------------------------------------------
module cnfp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  cnfp_pkg::pix_t              pixel_data,
  input  logic [cnfp_pkg::FW_W-1:0]   frame_width,
  input  logic [cnfp_pkg::FH_W-1:0]   frame_height,
  output logic                        rec_valid,
  output cnfp_pkg::rec_t              rec,
  input  logic                        rec_ready
);
  import cnfp_pkg::*;

  localparam logic [1:0] ST_PIPE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_SUMM  = 2'd3;

  logic [1:0]       state;
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;

  logic [COL_W-1:0] wlast;
  logic [ROW_W-1:0] hlast;
  logic             accept;
  logic [ROW_W-1:0] rs;
  logic [COL_W-1:0] cs;
  logic [COL_W-1:0] c;
  logic             eol;
  logic             eof;

  // line buffers
  logic [PIX_W-1:0] up_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_q;
  logic [PIX_W-1:0] mid_q;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;
  logic             byp;
  logic [PIX_W-1:0] byp_up;
  logic [PIX_W-1:0] byp_mid;

  // item stage
  logic             b_valid;
  logic [PIX_W-1:0] b_px;
  logic [ROW_W-1:0] b_row;
  logic [COL_W-1:0] b_col;
  logic             b_start;
  logic             b_eol;
  logic             b_eof;
  logic [COL_W-1:0] b_wlast;
  logic [2:0]       b_done;
  logic [PIX_W-1:0] b_up;
  logic [PIX_W-1:0] b_mid;
  logic [2:0][PIX_W-1:0] col_old;
  logic [2:0][PIX_W-1:0] col_new;
  win_t             win1;
  win_t             win2;
  logic             feat1;
  logic             feat2;
  logic             n_clr;
  logic             n_p1;
  logic             n_p2;
  logic             b_any;
  logic             b_rest;
  logic             b_retire;
  rec_t             b_rec;

  // bottom row walk
  logic [COL_W-1:0] fl_wlast;
  logic [ROW_W-1:0] fl_row;
  logic [COL_W:0]   fl_k;
  logic [COL_W:0]   fl_end;
  logic [1:0][PIX_W-1:0] fo;
  logic [1:0][PIX_W-1:0] fn;
  logic [PIX_W-1:0] fq_up;
  logic [PIX_W-1:0] fq_mid;
  win_t             fwin;
  logic             f_feat;
  logic             f_step;
  logic             fl_rd;
  logic [COL_W-1:0] fl_rd_addr;
  rec_t             f_rec;
  rec_t             s_rec;

  // effective geometry
  always_comb begin
    if (frame_width == '0) begin
      wlast = '0;
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      wlast = COL_W'(MAX_WIDTH - 1);
    end else begin
      wlast = COL_W'(frame_width - FW_W'(1));
    end
    if (frame_height == '0) begin
      hlast = '0;
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      hlast = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hlast = ROW_W'(frame_height - FH_W'(1));
    end
  end

  assign accept = push && !full;
  assign rs     = pixel_data.frame_start ? '0 : row_pos;
  assign cs     = pixel_data.frame_start ? '0 : col_pos;
  assign c      = (cs > wlast) ? wlast : cs;
  assign eol    = (c == wlast);
  assign eof    = eol && (rs >= hlast);

  // item stage datapath
  always_comb begin
    b_up  = (b_row >= ROW_W'(2)) ? (byp ? byp_up : up_q) : '0;
    b_mid = (b_row != '0) ? (byp ? byp_mid : mid_q) : '0;
    for (int i = 0; i < 3; i++) begin
      win1[3*i]     = (b_col == '0) ? '0 : col_old[i];
      win1[3*i + 1] = (b_col == '0) ? '0 : col_new[i];
    end
    win1[2] = b_up;
    win1[5] = b_mid;
    win1[8] = b_px;
    for (int i = 0; i < 3; i++) begin
      win2[3*i]     = win1[3*i + 1];
      win2[3*i + 1] = win1[3*i + 2];
      win2[3*i + 2] = '0;
    end
  end

  assign feat1 = (b_row != '0) && (b_col != '0) && is_feature(win1);
  assign feat2 = (b_row != '0) && b_eol && is_feature(win2);

  assign n_clr  = b_valid && b_start && !b_done[0];
  assign n_p1   = b_valid && feat1 && !b_done[1];
  assign n_p2   = b_valid && feat2 && !b_done[2];
  assign b_any  = n_clr || n_p1 || n_p2;
  assign b_rest = n_clr ? (n_p1 || n_p2) : (n_p1 && n_p2);
  assign b_retire = b_valid && (state == ST_PIPE) && (!b_any || (rec_ready && !b_rest));

  always_comb begin
    b_rec = '0;
    if (n_clr) begin
      b_rec.kind = REC_CLEAR;
    end else if (n_p1) begin
      b_rec.kind       = REC_POINT;
      b_rec.row        = b_row - ROW_W'(1);
      b_rec.col        = b_col - COL_W'(1);
      b_rec.feat_after = n_p2;
      b_rec.summ_after = b_eof;
    end else begin
      b_rec.kind       = REC_POINT;
      b_rec.row        = b_row - ROW_W'(1);
      b_rec.col        = b_col;
      b_rec.summ_after = b_eof;
    end
  end

  // bottom row walk datapath
  assign fl_end = {1'b0, fl_wlast} + (COL_W+1)'(1);
  assign fq_up  = (fl_k == fl_end) ? '0 : up_q;
  assign fq_mid = (fl_k == fl_end) ? '0 : mid_q;

  always_comb begin
    fwin    = '0;
    fwin[0] = fo[0];
    fwin[1] = fn[0];
    fwin[2] = fq_up;
    fwin[3] = fo[1];
    fwin[4] = fn[1];
    fwin[5] = fq_mid;
  end

  assign f_feat = (state == ST_FLUSH) && (fl_k != '0) && is_feature(fwin);
  assign f_step = (state == ST_FLUSH) && (!f_feat || rec_ready);
  assign fl_rd  = (state == ST_PRIME) || (f_step && (fl_k < {1'b0, fl_wlast}));
  assign fl_rd_addr = (state == ST_PRIME) ? '0 : COL_W'(fl_k + (COL_W+1)'(1));

  always_comb begin
    f_rec            = '0;
    f_rec.kind       = REC_POINT;
    f_rec.row        = fl_row;
    f_rec.col        = COL_W'(fl_k - (COL_W+1)'(1));
    f_rec.summ_after = 1'b1;
    s_rec            = '0;
    s_rec.kind       = REC_SUMMARY;
  end

  always_comb begin
    case (state)
      ST_PIPE: begin
        rec_valid = b_any;
        rec       = b_rec;
      end
      ST_FLUSH: begin
        rec_valid = f_feat;
        rec       = f_rec;
      end
      ST_SUMM: begin
        rec_valid = 1'b1;
        rec       = s_rec;
      end
      default: begin
        rec_valid = 1'b0;
        rec       = s_rec;
      end
    endcase
  end

  assign full = (state != ST_PIPE) || (b_valid && (b_eof || !b_retire));

  // line buffer ports
  assign rd_en   = accept || fl_rd;
  assign rd_addr = accept ? c : fl_rd_addr;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q  <= up_mem[rd_addr];
      mid_q <= mid_mem[rd_addr];
    end
    if (b_retire) begin
      up_mem[b_col]  <= b_mid;
      mid_mem[b_col] <= b_px;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_PIPE;
      row_pos <= '0;
      col_pos <= '0;
      b_valid <= 1'b0;
      b_done  <= '0;
    end else begin
      if (accept) begin
        col_pos <= eol ? '0 : c + COL_W'(1);
        row_pos <= eol ? (eof ? '0 : rs + ROW_W'(1)) : rs;
        b_valid <= 1'b1;
        b_done  <= '0;
      end else if (b_retire) begin
        b_valid <= 1'b0;
        b_done  <= '0;
      end else if (b_valid && (state == ST_PIPE) && rec_ready) begin
        if (n_clr) begin
          b_done[0] <= 1'b1;
        end else if (n_p1) begin
          b_done[1] <= 1'b1;
        end else begin
          b_done[2] <= 1'b1;
        end
      end
      case (state)
        ST_PIPE: begin
          if (b_retire && b_eof) begin
            state <= ST_PRIME;
          end
        end
        ST_PRIME: begin
          state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (f_step && (fl_k == fl_end)) begin
            state <= ST_SUMM;
          end
        end
        ST_SUMM: begin
          if (rec_ready) begin
            state <= ST_PIPE;
          end
        end
        default: begin
          state <= ST_PIPE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      b_px    <= pixel_data.pixel;
      b_row   <= rs;
      b_col   <= c;
      b_start <= pixel_data.frame_start;
      b_eol   <= eol;
      b_eof   <= eof;
      b_wlast <= wlast;
      byp     <= b_valid && (c == b_col);
      byp_up  <= b_mid;
      byp_mid <= b_px;
    end
    if (b_retire) begin
      col_old <= (b_col == '0) ? '0 : col_new;
      col_new <= {b_px, b_mid, b_up};
    end
    if (state == ST_PIPE && b_retire && b_eof) begin
      fl_wlast <= b_wlast;
      fl_row   <= b_row;
    end
    if (state == ST_PRIME) begin
      fl_k <= '0;
      fo   <= '0;
      fn   <= '0;
    end else if (f_step) begin
      fo   <= fn;
      fn   <= {fq_mid, fq_up};
      fl_k <= fl_k + (COL_W+1)'(1);
    end
  end

endmodule

### hw/rtl/cnfp_queue.sv
// ----------------------------------------------------------------------------
// cnfp_queue
// Short record queue between the classifying front and the counting back.
// ----------------------------------------------------------------------------
module cnfp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cnfp_pkg::rec_t in_rec,
  output logic           out_valid,
  input  logic           out_ready,
  output cnfp_pkg::rec_t out_rec
);
  import cnfp_pkg::*;

  rec_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              wr;
  logic              rd;

  assign in_ready  = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_rec   = slots[rd_ptr];
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (wr && !rd) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (rd && !wr) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= in_rec;
    end
  end

endmodule

### hw/rtl/cnfp_back.sv
// ----------------------------------------------------------------------------
// cnfp_back
// Applies the point cap, keeps count and overflow, holds the result item.
// ----------------------------------------------------------------------------
module cnfp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           rec_valid,
  output logic           rec_take,
  input  cnfp_pkg::rec_t rec,
  output logic           empty,
  input  logic           pop,
  output cnfp_pkg::res_t point_data
);
  import cnfp_pkg::*;

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             out_valid;
  logic             room;
  logic             emits;
  logic [CNT_W-1:0] count_inc;
  res_t             res;

  assign room      = count < CNT_W'(MAX_POINTS);
  assign count_inc = count + CNT_W'(1);
  assign emits     = (rec.kind == REC_SUMMARY) || ((rec.kind == REC_POINT) && room);
  assign rec_take  = rec_valid && (!emits || !out_valid || pop);
  assign empty     = !out_valid;

  always_comb begin
    res = '0;
    if (rec.kind == REC_SUMMARY) begin
      res.is_summary  = 1'b1;
      res.point_count = count;
      res.overflow    = ovf;
      res.last        = 1'b1;
    end else begin
      res.point_row   = rec.row;
      res.point_col   = rec.col;
      res.point_count = count_inc;
      res.overflow    = ovf;
      res.last        = !rec.summ_after &&
                        (!rec.feat_after || (count_inc == CNT_W'(MAX_POINTS)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b0;
      end
      if (rec_take) begin
        case (rec.kind)
          REC_CLEAR: begin
            count <= '0;
            ovf   <= 1'b0;
          end
          REC_POINT: begin
            if (room) begin
              count     <= count_inc;
              out_valid <= 1'b1;
            end else begin
              ovf <= 1'b1;
            end
          end
          REC_SUMMARY: begin
            count     <= '0;
            ovf       <= 1'b0;
            out_valid <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take && emits) begin
      point_data <= res;
    end
  end

endmodule

### hw/rtl/crossing_number_feature_points.sv
// ----------------------------------------------------------------------------
// crossing_number_feature_points
// Streaming 3x3 crossing number feature point extractor for skeleton frames.
// ----------------------------------------------------------------------------
//  channel     handshake            payload
//  pixels      push / full          pixel_data : pixel, frame_start
//  results     pop / empty          point_data : row, col, summary, count, ...
//  config      cfg_we               cfg_index, cfg_data
//
//  One pixel per clock while full is low. An item that queues more than one
//  record (frame start mark, two points at a row end) holds the input until
//  all of its records are queued.
//  The last pixel of a frame walks the bottom row through the line buffer
//  read port and then sends the summary record; the input is held meanwhile.
//  A 4-entry record queue and the result register absorb stalls on pop.
//  Synchronous reset; line buffers are not cleared, no clearing pass.
// ----------------------------------------------------------------------------
module crossing_number_feature_points (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  cnfp_pkg::pix_t                   pixel_data,
  output logic                             empty,
  input  logic                             pop,
  output cnfp_pkg::res_t                   point_data,
  input  logic                             cfg_we,
  input  logic [cnfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cnfp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cnfp_pkg::*;

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;

  logic f_valid;
  logic f_ready;
  rec_t f_rec;
  logic q_valid;
  logic q_take;
  rec_t q_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cnfp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pixel_data   (pixel_data),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .rec_valid    (f_valid),
    .rec          (f_rec),
    .rec_ready    (f_ready)
  );

  cnfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_rec    (f_rec),
    .out_valid (q_valid),
    .out_ready (q_take),
    .out_rec   (q_rec)
  );

  cnfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rec_valid  (q_valid),
    .rec_take   (q_take),
    .rec        (q_rec),
    .empty      (empty),
    .pop        (pop),
    .point_data (point_data)
  );

endmodule
